// File: rtl/core/slrr_pkg.sv
// Package for the serpentine LED rotation remap: coordinate type, grid constants
// and the row start table of the serpentine strip.
// Depends on nothing; used by serpentine_led_rotation_remap.
`default_nettype none

package slrr_pkg;

    // Grid coordinate: -1 and 11 mark the corner dots outside the grid.
    typedef logic signed [4:0] t_coord;

    localparam t_coord GRID_LAST   = 5'sd10;
    localparam t_coord OUTSIDE_LO  = -5'sd1;
    localparam t_coord OUTSIDE_HI  = 5'sd11;
    localparam t_coord GRID_CENTRE = 5'sd5;

    localparam logic [7:0] DOT_TOP_LEFT     = 8'd124;
    localparam logic [7:0] DOT_TOP_RIGHT    = 8'd123;
    localparam logic [7:0] DOT_BOTTOM_RIGHT = 8'd12;
    localparam logic [7:0] DOT_BOTTOM_LEFT  = 8'd0;
    localparam logic [7:0] LAST_GRID_LED    = 8'd122;

    // Rotation codes of the quarter_turns register, clockwise.
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_90   = 2'd1;
    localparam logic [1:0] ROT_180  = 2'd2;
    localparam logic [1:0] ROT_270  = 2'd3;

    localparam int ROWS = 11;

    // First strip index of each row, counted from the bottom row.
    function automatic logic [7:0] row_start(input logic [3:0] rb);
        logic [7:0] s;
        case (rb)
            4'd0:    s = 8'd1;
            4'd1:    s = 8'd13;
            4'd2:    s = 8'd24;
            4'd3:    s = 8'd35;
            4'd4:    s = 8'd46;
            4'd5:    s = 8'd57;
            4'd6:    s = 8'd68;
            4'd7:    s = 8'd79;
            4'd8:    s = 8'd90;
            4'd9:    s = 8'd101;
            4'd10:   s = 8'd112;
            default: s = 8'd112;
        endcase
        return s;
    endfunction

    // Stage 1 result: row band found by comparison against the row starts.
    typedef struct packed {
        logic [1:0] q;
        logic [7:0] idx;
        logic [3:0] rb;
    } t_band;

    // Stage 2 and 3 result: grid place of the item.
    typedef struct packed {
        logic [1:0] q;
        logic [7:0] idx;
        t_coord     row;
        t_coord     col;
    } t_place;

endpackage

`default_nettype wire

// File: rtl/core/serpentine_led_rotation_remap.sv
// Rotation remap for an 11x11 serpentine-wired LED grid with four corner dots.
// Throughput: one transaction per clock while the output is not stalled; a stall holds only the stages that are full.
// Reset (synchronous, active low) clears all stage valid bits and sets
// quarter_turns to 0 (no rotation). Depends on slrr_pkg.
`default_nettype none

module serpentine_led_rotation_remap
    import slrr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write channel.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_quarter_turns,
    // Input channel.
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_led_index,
    // Output channel.
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_mapped_index
);

    // The pipeline has four register stages:
    //   1. band:  the row band (counted from the bottom) is found by comparing the
    //             index with every row start above the first at once.
    //   2. place: the offset within the row gives the row and column; the corner
    //             dots and out-of-grid indices get their fixed places.
    //   3. turn:  the place is rotated clockwise. The plain formulas also move the
    //             outside coordinates of the corner dots onto the rotated corners.
    //   4. out:   the rotated place is turned back into a strip index, or the
    //             original index is passed through when there is no rotation.
    // The rotation setting travels with each transaction, so the result always
    // uses the setting that was live when the index was accepted.
    // Each stage loads when it is empty or when the stage after it moves, so
    // bubbles are squeezed out and a stalled output holds without loss.

    logic [1:0] r_quarter_turns;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter_turns <= ROT_NONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_quarter_turns <= i_quarter_turns;
        end
    end

    // Stage enables, from the output back to the input.
    logic r_v1, r_v2, r_v3, r_vo;
    logic en1, en2, en3, eno;

    assign eno     = !r_vo || !i_stall;
    assign en3     = !r_v3 || eno;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (eno) begin
                r_vo <= r_v3;
            end
        end
    end

    // Stage 1: row band. The band is the number of row starts above the first
    // that the index has reached.
    t_band n_s1, r_s1;

    always_comb begin
        n_s1.q   = r_quarter_turns;
        n_s1.idx = i_led_index;
        n_s1.rb  = 4'd0;
        for (int k = 1; k < ROWS; k++) begin
            n_s1.rb = n_s1.rb + 4'(i_led_index >= row_start(4'(k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
    end

    // Stage 2: grid place.
    t_place     n_s2, r_s2;
    logic [7:0] s2_off;
    logic [3:0] s2_pos;

    always_comb begin
        s2_off   = r_s1.idx - row_start(r_s1.rb);
        s2_pos   = s2_off[3:0];
        n_s2.q   = r_s1.q;
        n_s2.idx = r_s1.idx;
        n_s2.row = GRID_LAST - $signed({1'b0, r_s1.rb});
        n_s2.col = r_s1.rb[0] ? (GRID_LAST - $signed({1'b0, s2_pos}))
                              : $signed({1'b0, s2_pos});
        if (r_s1.idx == DOT_TOP_LEFT) begin
            n_s2.row = OUTSIDE_LO;
            n_s2.col = OUTSIDE_LO;
        end else if (r_s1.idx == DOT_TOP_RIGHT) begin
            n_s2.row = OUTSIDE_LO;
            n_s2.col = OUTSIDE_HI;
        end else if (r_s1.idx == DOT_BOTTOM_RIGHT) begin
            n_s2.row = OUTSIDE_HI;
            n_s2.col = OUTSIDE_HI;
        end else if (r_s1.idx == DOT_BOTTOM_LEFT) begin
            n_s2.row = OUTSIDE_HI;
            n_s2.col = OUTSIDE_LO;
        end else if (r_s1.idx > LAST_GRID_LED) begin
            // Any index beyond the grid and the dots stands for the centre cell.
            n_s2.row = GRID_CENTRE;
            n_s2.col = GRID_CENTRE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2 <= n_s2;
        end
    end

    // Stage 3: clockwise rotation by the number of quarter turns.
    t_place n_s3, r_s3;

    always_comb begin
        n_s3 = r_s2;
        case (r_s2.q)
            ROT_90: begin
                n_s3.row = r_s2.col;
                n_s3.col = GRID_LAST - r_s2.row;
            end
            ROT_180: begin
                n_s3.row = GRID_LAST - r_s2.row;
                n_s3.col = GRID_LAST - r_s2.col;
            end
            ROT_270: begin
                n_s3.row = GRID_LAST - r_s2.col;
                n_s3.col = r_s2.row;
            end
            default: begin
                n_s3 = r_s2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3 <= n_s3;
        end
    end

    // Stage 4: back to a strip index.
    t_coord     s4_row, s4_col;
    logic [3:0] s4_rb, s4_cu;
    logic [7:0] s4_start, n_out, r_out;

    always_comb begin
        s4_row = r_s3.row;
        s4_col = r_s3.col;
        if (s4_row < 5'sd0) begin
            s4_row = 5'sd0;
        end
        if (s4_row > GRID_LAST) begin
            s4_row = GRID_LAST;
        end
        if (s4_col < 5'sd0) begin
            s4_col = 5'sd0;
        end
        if (s4_col > GRID_LAST) begin
            s4_col = GRID_LAST;
        end
        s4_rb    = 4'(unsigned'(GRID_LAST - s4_row));
        s4_cu    = 4'(unsigned'(s4_col));
        s4_start = row_start(s4_rb);
        n_out    = s4_rb[0] ? (s4_start + 8'd10 - {4'd0, s4_cu})
                            : (s4_start + {4'd0, s4_cu});
        if (r_s3.row == OUTSIDE_LO && r_s3.col == OUTSIDE_LO) begin
            n_out = DOT_TOP_LEFT;
        end else if (r_s3.row == OUTSIDE_LO && r_s3.col == OUTSIDE_HI) begin
            n_out = DOT_TOP_RIGHT;
        end else if (r_s3.row == OUTSIDE_HI && r_s3.col == OUTSIDE_HI) begin
            n_out = DOT_BOTTOM_RIGHT;
        end else if (r_s3.row == OUTSIDE_HI && r_s3.col == OUTSIDE_LO) begin
            n_out = DOT_BOTTOM_LEFT;
        end
        // Without rotation every index, even one beyond the grid, passes through.
        if (r_s3.q == ROT_NONE) begin
            n_out = r_s3.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eno) begin
            r_out <= n_out;
        end
    end

    assign o_mapped_index = r_out;

endmodule

`default_nettype wire
